// ===== sv/tfd_pkg.sv =====
// Shared types and constants for the telemetry frame decoder.
package tfd_pkg;

    localparam logic [7:0] FRAME_HEADER      = 8'hAE;
    localparam logic [3:0] FRAME_LEN         = 4'd9;
    localparam logic [3:0] CHECK_POS         = 4'd8;
    localparam logic [7:0] FAULT_EXHAUST_BIT = 8'h01;
    localparam logic [7:0] FAULT_HEAD_BIT    = 8'h02;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd2000;
    localparam logic [15:0] AGE_MAX          = 16'hFFFF;
    localparam int unsigned RESULT_W         = 53;
    localparam int unsigned M_TDATA_W        = 56;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef struct packed {
        action_t    action;
        logic       last_byte;
        logic [7:0] data_byte;
    } in_word_t;

    // First member sits in the highest bits: listed from the top of the word down.
    typedef struct packed {
        logic               frame_dropped;
        logic               frame_accepted;
        logic               head_fault;
        logic               exhaust_fault;
        logic signed [15:0] head_temp_tenths;
        logic signed [15:0] exhaust_temp_tenths;
        logic [15:0]        rpm;
        logic               telemetry_valid;
    } result_t;

endpackage

// ===== sv/telemetry_frame_decoder.sv =====
// Top level of the telemetry frame decoder: input stage, decoder core, result stage.
//
// Usage:
//   The slave channel carries one word per byte of an engine notification
//   (s_tuser low, s_tdata the byte, s_tlast on the final byte) or a one
//   millisecond tick (s_tuser high, s_tdata and s_tlast ignored).
//   Every accepted word yields exactly one result word on the master channel,
//   holding the latched telemetry, its fresh flag and the accept/drop strobes.
//   A word is held in the input stage, its result then in the result stage.
//   Throughput: one word per cycle while m_tready is high; each stage holds
//   one word, so a word is taken while an earlier result waits.
//   When the receiver holds m_tready low, the result stage holds its word and
//   the input stage fills; s_tready drops once both are occupied.
//   Reset (aresetn low, synchronous) empties both stages, clears the frame in
//   progress and the latched telemetry, and sets the timeout to 2000 ms.
//   cfg_wr_en writes cfg_wr_data into the stale timeout; write it only while
//   no word is in flight.
module telemetry_frame_decoder
    import tfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic [0:0]           s_tuser,   // [0] action
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] telemetry_valid, [16:1] rpm, [32:17] exhaust_temp_tenths,
    // [48:33] head_temp_tenths, [49] exhaust_fault, [50] head_fault,
    // [51] frame_accepted, [52] frame_dropped, [55:53] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data
);

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic [15:0] timeout_reg;
    logic        out_free;
    logic        advance;
    result_t     core_result;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= '{action: action_t'(s_tuser[0]), last_byte: s_tlast,
                             data_byte: s_tdata};
        end
    end

    tfd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_en       (advance),
        .item          (in_word_reg),
        .stale_timeout (timeout_reg),
        .result        (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

endmodule

// ===== sv/tfd_core.sv =====
// Frame assembly, checksum check, telemetry latch and staleness aging.
module tfd_core
    import tfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_en,
    input  in_word_t    item,
    input  logic [15:0] stale_timeout,
    output result_t     result
);

    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic        hdr_reg, hdr_next;
    logic [7:0]  fb_reg [7];
    logic        fb_wr_en;
    logic [2:0]  fb_wr_idx;
    logic [15:0] rpm_reg, rpm_next;
    logic [15:0] egt_reg, egt_next;
    logic [15:0] cht_reg, cht_next;
    logic [1:0]  faults_reg, faults_next;
    logic        valid_reg, valid_next;
    logic [15:0] age_reg, age_next;
    logic        ok;
    logic        accepted;
    logic        dropped;

    always_comb begin
        idx_next    = idx_reg;
        xor_next    = xor_reg;
        hdr_next    = hdr_reg;
        rpm_next    = rpm_reg;
        egt_next    = egt_reg;
        cht_next    = cht_reg;
        faults_next = faults_reg;
        valid_next  = valid_reg;
        age_next    = age_reg;
        fb_wr_en    = 1'b0;
        fb_wr_idx   = idx_reg[2:0] - 3'd1;
        ok          = (idx_reg == CHECK_POS) && hdr_reg && (item.data_byte == xor_reg);
        accepted    = 1'b0;
        dropped     = 1'b0;
        unique case (item.action)
            ACT_TICK: begin
                if (age_reg != AGE_MAX) begin
                    age_next = age_reg + 16'd1;
                end
                if (valid_reg && (age_next > stale_timeout)) begin
                    valid_next = 1'b0;
                end
            end
            ACT_BYTE: begin
                if (idx_reg == 4'd0) begin
                    hdr_next = (item.data_byte == FRAME_HEADER);
                end else if (idx_reg < CHECK_POS) begin
                    fb_wr_en = 1'b1;
                end
                if (idx_reg < CHECK_POS) begin
                    xor_next = xor_reg ^ item.data_byte;
                end
                if (idx_reg < FRAME_LEN) begin
                    idx_next = idx_reg + 4'd1;
                end
                if (item.last_byte) begin
                    accepted = ok;
                    dropped  = !ok;
                    if (ok) begin
                        rpm_next    = {fb_reg[1], fb_reg[0]};
                        egt_next    = {fb_reg[3], fb_reg[2]};
                        cht_next    = {fb_reg[5], fb_reg[4]};
                        faults_next = {|(fb_reg[6] & FAULT_HEAD_BIT),
                                       |(fb_reg[6] & FAULT_EXHAUST_BIT)};
                        valid_next  = 1'b1;
                        age_next    = 16'd0;
                    end
                    idx_next = 4'd0;
                    xor_next = 8'd0;
                    hdr_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.telemetry_valid     = valid_next;
        result.rpm                 = rpm_next;
        result.exhaust_temp_tenths = egt_next;
        result.head_temp_tenths    = cht_next;
        result.exhaust_fault       = faults_next[0];
        result.head_fault          = faults_next[1];
        result.frame_accepted      = accepted;
        result.frame_dropped       = dropped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= 4'd0;
            xor_reg    <= 8'd0;
            hdr_reg    <= 1'b0;
            rpm_reg    <= 16'd0;
            egt_reg    <= 16'd0;
            cht_reg    <= 16'd0;
            faults_reg <= 2'd0;
            valid_reg  <= 1'b0;
            age_reg    <= 16'd0;
        end else if (item_en) begin
            idx_reg    <= idx_next;
            xor_reg    <= xor_next;
            hdr_reg    <= hdr_next;
            rpm_reg    <= rpm_next;
            egt_reg    <= egt_next;
            cht_reg    <= cht_next;
            faults_reg <= faults_next;
            valid_reg  <= valid_next;
            age_reg    <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en && fb_wr_en) begin
            fb_reg[fb_wr_idx] <= item.data_byte;
        end
    end

endmodule

// ===== sv/tfd_checker.sv =====
// Port-level checks for the telemetry frame decoder, bound to the top level.
module tfd_checker
    import tfd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    result_t res;

    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.frame_accepted && res.frame_dropped))
        else $error("frame both accepted and dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.frame_accepted |-> res.telemetry_valid)
        else $error("accepted frame not marked fresh");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

endmodule

bind telemetry_frame_decoder tfd_checker u_tfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/telemetry_frame_decoder_test.sv =====
// Self-checking testbench for telemetry_frame_decoder: directed table, random frames, timeouts.
`timescale 1ns / 1ps

module telemetry_frame_decoder_test;
    import tfd_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef enum int {
        KIND_GOOD,
        KIND_BAD_HEADER,
        KIND_BAD_CHECK,
        KIND_SHORT,
        KIND_LONG,
        KIND_TICKS,
        KIND_NOISE
    } frame_kind_t;

    typedef struct packed {
        in_word_t word;
        logic     typed;
        result_t  outcome;
    } directed_row_t;

    localparam result_t TELEM_CLEAR      = '0;
    localparam result_t TELEM_SHORT_DROP = '{frame_dropped: 1'b1, default: '0};
    localparam result_t TELEM_FULL_SCALE = '{
        frame_dropped:       1'b0,
        frame_accepted:      1'b1,
        head_fault:          1'b1,
        exhaust_fault:       1'b1,
        head_temp_tenths:    16'sh7FFF,
        exhaust_temp_tenths: 16'sh8000,
        rpm:                 16'hFFFF,
        telemetry_valid:     1'b1
    };

    localparam directed_row_t DIRECTED_ROWS [24] = '{
        '{'{ACT_TICK, 1'b0, 8'h00}, 1'b1, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b1, 8'hAE}, 1'b1, TELEM_SHORT_DROP},
        // full-scale frame with a tick in the middle
        '{'{ACT_BYTE, 1'b0, 8'hAE}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'hFF}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'hFF}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h80}, 1'b0, TELEM_CLEAR},
        '{'{ACT_TICK, 1'b1, 8'h5A}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'hFF}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h7F}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h03}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b1, 8'hAD}, 1'b1, TELEM_FULL_SCALE},
        '{'{ACT_TICK, 1'b0, 8'hFF}, 1'b0, TELEM_CLEAR},
        // overlong frame: good checksum at byte 8, ends at byte 9
        '{'{ACT_BYTE, 1'b0, 8'hAE}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b0, 8'hAE}, 1'b0, TELEM_CLEAR},
        '{'{ACT_BYTE, 1'b1, 8'h00}, 1'b0, TELEM_CLEAR},
        '{'{ACT_TICK, 1'b0, 8'h00}, 1'b0, TELEM_CLEAR}
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = '0;
    logic [0:0]           s_tuser     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic [15:0]          cfg_wr_data = '0;

    // decoder state as predicted
    logic [3:0]         frame_pos     = '0;
    logic [7:0]         frame_xor     = '0;
    logic               header_ok     = 1'b0;
    logic [7:0]         payload [0:6] = '{default: '0};
    logic [15:0]        held_rpm      = '0;
    logic signed [15:0] held_exhaust  = '0;
    logic signed [15:0] held_head     = '0;
    logic [7:0]         held_faults   = '0;
    logic               fresh         = 1'b0;
    logic [15:0]        age           = '0;
    logic [15:0]        timeout_ms    = TIMEOUT_RESET;

    result_t expected_telemetry [$];
    int      mismatch_count = 0;
    int      words_sent     = 0;
    int      stalled_cycles = 0;
    int      hold_left      = 0;
    bit      quiet_phase    = 1'b0;

    telemetry_frame_decoder DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    function result_t predict_telemetry(input in_word_t w);
        result_t    r;
        logic [3:0] pos;
        logic       ok;
        r = '0;
        pos = frame_pos;
        if (w.action == ACT_TICK) begin
            if (age != AGE_MAX) age = age + 16'd1;
            if (fresh && age > timeout_ms) fresh = 1'b0;
        end else begin
            if (pos == 4'd0) begin
                header_ok = (w.data_byte == FRAME_HEADER);
            end else if (pos < CHECK_POS) begin
                payload[3'(pos - 4'd1)] = w.data_byte;
            end
            if (pos < CHECK_POS) frame_xor = frame_xor ^ w.data_byte;
            if (pos < FRAME_LEN) frame_pos = pos + 4'd1;
            if (w.last_byte) begin
                ok = (pos == CHECK_POS) && header_ok && (w.data_byte == frame_xor);
                if (ok) begin
                    held_rpm     = {payload[1], payload[0]};
                    held_exhaust = {payload[3], payload[2]};
                    held_head    = {payload[5], payload[4]};
                    held_faults  = payload[6] & (FAULT_EXHAUST_BIT | FAULT_HEAD_BIT);
                    fresh        = 1'b1;
                    age          = '0;
                end
                frame_pos = '0;
                frame_xor = '0;
                header_ok = 1'b0;
                r.frame_accepted = ok;
                r.frame_dropped  = !ok;
            end
        end
        r.telemetry_valid     = fresh;
        r.rpm                 = held_rpm;
        r.exhaust_temp_tenths = held_exhaust;
        r.head_temp_tenths    = held_head;
        r.exhaust_fault       = |(held_faults & FAULT_EXHAUST_BIT);
        r.head_fault          = |(held_faults & FAULT_HEAD_BIT);
        return r;
    endfunction

    function automatic string describe_telemetry(input result_t t);
        return $sformatf({"valid=%0b rpm=%0d egt=%0d cht=%0d ",
                          "egt_fault=%0b cht_fault=%0b acc=%0b drop=%0b"},
            t.telemetry_valid, t.rpm, t.exhaust_temp_tenths, t.head_temp_tenths,
            t.exhaust_fault, t.head_fault, t.frame_accepted, t.frame_dropped);
    endfunction

    function automatic frame_kind_t random_frame_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return KIND_GOOD;
        if (pick < 58) return KIND_BAD_HEADER;
        if (pick < 66) return KIND_BAD_CHECK;
        if (pick < 74) return KIND_SHORT;
        if (pick < 80) return KIND_LONG;
        if (pick < 94) return KIND_TICKS;
        return KIND_NOISE;
    endfunction

    task automatic send_word(input in_word_t w, input logic typed = 1'b0,
                             input result_t typed_outcome = '0);
        result_t predicted;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.action;
        s_tdata  <= w.data_byte;
        s_tlast  <= w.last_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_telemetry(w);
        expected_telemetry.push_back(typed ? typed_outcome : predicted);
        words_sent++;
    endtask

    task automatic send_tick();
        in_word_t w;
        w.action    = ACT_TICK;
        w.last_byte = 1'($urandom_range(0, 1));
        w.data_byte = 8'($urandom);
        send_word(w);
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] body [0:11];
        int         length;
        in_word_t   w;
        if (kind == KIND_TICKS) begin
            repeat ($urandom_range(1, 30)) send_tick();
            return;
        end
        w.action = ACT_BYTE;
        if (kind == KIND_NOISE) begin
            w.last_byte = 1'($urandom_range(0, 1));
            w.data_byte = 8'($urandom);
            send_word(w);
            return;
        end
        foreach (body[i]) body[i] = 8'($urandom);
        body[0] = FRAME_HEADER;
        if (kind == KIND_BAD_HEADER) begin
            while (body[0] == FRAME_HEADER) body[0] = 8'($urandom);
        end
        body[8] = '0;
        for (int i = 0; i < 8; i++) body[8] = body[8] ^ body[i];
        if (kind == KIND_BAD_CHECK) body[8] = body[8] ^ 8'(1 << $urandom_range(0, 7));
        if (kind == KIND_SHORT) length = $urandom_range(1, 8);
        else if (kind == KIND_LONG) length = $urandom_range(10, 12);
        else length = 9;
        for (int i = 0; i < length; i++) begin
            if ($urandom_range(0, 7) == 0) send_tick();
            w.last_byte = (i == length - 1);
            w.data_byte = body[i];
            send_word(w);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_telemetry.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        timeout_ms = value;
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        result_t observed;
        result_t wanted;
        observed = result_t'(m_tdata[RESULT_W-1:0]);
        if (m_tvalid && m_tready) begin
            if (expected_telemetry.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected word: %s", describe_telemetry(observed));
                end
                mismatch_count++;
            end else begin
                wanted = expected_telemetry.pop_front();
                if (observed !== wanted) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", describe_telemetry(wanted));
                        $display("  actual   %s", describe_telemetry(observed));
                    end
                    mismatch_count++;
                end
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIRECTED_ROWS[i]) begin
            send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].outcome);
        end

        while (words_sent < 300) send_frame(random_frame_kind());
        hold_until_drained();
        while (words_sent < 340) send_frame(random_frame_kind());

        set_timeout(16'($urandom_range(1, 25)));
        while (words_sent < 560) send_frame(random_frame_kind());

        set_timeout(16'd0);
        while (words_sent < 690) send_frame(random_frame_kind());

        // hold the data fresh with the largest timeout
        quiet_phase = 1'b1;
        set_timeout(AGE_MAX);
        send_frame(KIND_GOOD);
        repeat (8) send_tick();
        send_frame(KIND_GOOD);
        send_tick();

        hold_until_drained();
        if (mismatch_count == 0 && expected_telemetry.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tfd_pkg.sv
sv/tfd_core.sv
sv/telemetry_frame_decoder.sv
sv/tfd_checker.sv
test/telemetry_frame_decoder_test.sv
